[hdl/slcan_pkg.sv]
// Shared types, character codes and small helper functions for the serial CAN
// command interpreter. No dependencies; every other file of the block imports it.
`default_nettype none
package slcan_pkg;

  // Input item codes.
  localparam logic [1:0] CMD_HOST  = 2'd0;
  localparam logic [1:0] CMD_FRAME = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // Result kinds.
  localparam logic [2:0] KIND_BYTE = 3'd0;
  localparam logic [2:0] KIND_TX   = 3'd1;
  localparam logic [2:0] KIND_RATE = 3'd2;
  localparam logic [2:0] KIND_BAUD = 3'd3;
  localparam logic [2:0] KIND_MON  = 3'd4;

  // Reply text that follows the optional request of a job.
  localparam logic [2:0] TXT_NONE  = 3'd0;
  localparam logic [2:0] TXT_BELL  = 3'd1;
  localparam logic [2:0] TXT_CR    = 3'd2;
  localparam logic [2:0] TXT_ZCR   = 3'd3;
  localparam logic [2:0] TXT_FSTAT = 3'd4;
  localparam logic [2:0] TXT_VER   = 3'd5;
  localparam logic [2:0] TXT_SER   = 3'd6;
  localparam logic [2:0] TXT_FRAME = 3'd7;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_BELL  = 8'h07;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_SIX   = 8'h36;
  localparam logic [7:0] CH_EIGHT = 8'h38;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_LT    = 8'h74;
  localparam logic [7:0] CH_UT    = 8'h54;
  localparam logic [7:0] CH_LR    = 8'h72;
  localparam logic [7:0] CH_UR    = 8'h52;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_U     = 8'h55;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_V     = 8'h56;
  localparam logic [7:0] CH_N     = 8'h4E;

  localparam logic [28:0] STD_ID_LIMIT = 29'h800;
  localparam logic [3:0]  MAX_DLC      = 4'd8;

  typedef struct packed {
    logic       take;
    logic       load;
    logic [5:0] step;
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] total;
  } dp_stat_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  reply_byte;
    logic        last;
    logic [31:0] tx_id;
    logic        tx_extended;
    logic        tx_remote;
    logic [3:0]  tx_len;
    logic [63:0] tx_data;
    logic [3:0]  rate_code;
    logic        monitor_on;
  } res_t;

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h37 + {4'd0, n});
  endfunction

  // Bit 4 set when the character is a hex digit, nibble value below it.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    return r;
  endfunction

  function automatic logic [7:0] ver_char(input logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0: r = CH_V;
      3'd1: r = 8'h31;
      3'd2: r = 8'h32;
      3'd3: r = 8'h32;
      3'd4: r = 8'h30;
      default: r = CH_CR;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] ser_char(input logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0: r = CH_N;
      3'd1: r = 8'h41;
      3'd2: r = 8'h31;
      3'd3: r = 8'h32;
      3'd4: r = 8'h33;
      default: r = CH_CR;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[hdl/slcan_ctrl.sv]
// Sequencer of the command interpreter: accepts items and steps through the
// results of each one. Depends on slcan_pkg.
`default_nettype none
module slcan_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output slcan_pkg::dp_cmd_t cmd_o,
  input  slcan_pkg::dp_stat_t stat_i
);
  import slcan_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic       state_q, state_d;
  logic [5:0] step_q, step_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free, more, load, take;

  always_comb begin
    slot_free = !out_valid_q || !out_stall_i;
    more      = step_q != stat_i.total;
    load      = (state_q == ST_RUN) && more && slot_free;
    take      = (state_q == ST_IDLE) && in_valid_i;
    state_d   = state_q;
    step_d    = step_q;
    case (state_q)
      ST_IDLE: begin
        if (take) begin
          state_d = ST_RUN;
          step_d  = 6'd0;
        end
      end
      ST_RUN: begin
        if (!more) state_d = ST_IDLE;
        else if (load) step_d = step_q + 6'd1;
      end
      default: state_d = ST_IDLE;
    endcase
    out_valid_d = load ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= 6'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = state_q == ST_RUN;
  assign out_valid_o = out_valid_q;
  assign cmd_o.take  = take;
  assign cmd_o.load  = load;
  assign cmd_o.step  = step_q;

endmodule
`default_nettype wire

[hdl/slcan_dp.sv]
// Datapath of the command interpreter: line parser, mode flags, timestamp,
// job registers, result formatter and output register. Depends on slcan_pkg.
`default_nettype none
module slcan_dp #(
  parameter int LINE_MAX      = 32,
  parameter int STAMP_WRAP_MS = 60000
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  slcan_pkg::dp_cmd_t  cmd_i,
  input  logic [1:0]          cmd_in_i,
  input  logic [7:0]          host_byte_i,
  input  logic [7:0]          bus_status_i,
  input  logic [28:0]         rx_id_i,
  input  logic [3:0]          rx_len_i,
  input  logic [63:0]         rx_data_i,
  output slcan_pkg::dp_stat_t stat_o,
  output slcan_pkg::res_t     res_o
);
  import slcan_pkg::*;

  localparam int CW = $clog2(LINE_MAX + 1);

  // Line parse state. The line is decoded as it arrives, so only the first
  // three characters, the identifier, length and data fields are kept.
  logic [CW-1:0] cnt_q;
  logic          ovf_q;
  logic [7:0]    c0_q, c1_q, c2_q;
  logic [31:0]   id_q;
  logic [3:0]    len_q;
  logic [63:0]   data_q;
  logic          allhex_q;

  logic brset_q, open_q, listen_q, apoll_q, st_on_q;
  logic brset_d, open_d, listen_d, apoll_d, st_on_d;
  logic [15:0] stamp_q, stamp_d;

  // Job registers: what the current item answers.
  logic        job_req_q, job_req_d;
  logic [2:0]  job_kind_q, job_kind_d;
  logic [2:0]  job_txt_q, job_txt_d;
  logic [31:0] job_id_q, job_id_d;
  logic        job_ext_q, job_ext_d;
  logic        job_rem_q, job_rem_d;
  logic [3:0]  job_len_q, job_len_d;
  logic [63:0] job_data_q, job_data_d;
  logic [3:0]  job_rate_q, job_rate_d;
  logic        job_mon_q, job_mon_d;
  logic [15:0] job_stamp_q, job_stamp_d;
  logic        job_st_on_q, job_st_on_d;
  logic [7:0]  job_status_q, job_status_d;

  res_t out_q, res;

  logic [6:0]  pos, lenpos, dofs, endpos, n7;
  logic [3:0]  idn;
  logic [4:0]  hv;
  logic        ext_l, rem_l, store;
  logic [16:0] inc;

  always_comb begin
    pos    = 7'(cnt_q);
    n7     = 7'(cnt_q);
    ext_l  = (c0_q == CH_UT) || (c0_q == CH_UR);
    rem_l  = (c0_q == CH_LR) || (c0_q == CH_UR);
    idn    = ext_l ? 4'd8 : 4'd3;
    lenpos = ext_l ? 7'd9 : 7'd4;
    dofs   = pos - lenpos - 7'd1;
    endpos = lenpos + 7'd1 + (rem_l ? 7'd0 : {2'b00, len_q, 1'b0});
    hv     = hex_val(host_byte_i);
    store  = cmd_i.take && (cmd_in_i == CMD_HOST) && (host_byte_i != CH_CR) &&
             (cnt_q < CW'(LINE_MAX));
    inc    = {1'b0, stamp_q} + 17'd1;
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      if (pos == 7'd0) begin
        c0_q     <= host_byte_i;
        id_q     <= 32'd0;
        data_q   <= 64'd0;
        allhex_q <= 1'b1;
      end else begin
        if (!hv[4]) allhex_q <= 1'b0;
        if (pos <= {3'd0, idn}) id_q <= {id_q[27:0], hv[3:0]};
        if (pos == lenpos) len_q <= hv[3:0];
        if (pos > lenpos && dofs < 7'd16) begin
          data_q[{dofs[3:1], ~dofs[0], 2'b00} +: 4] <= hv[3:0];
        end
      end
      if (pos == 7'd1) c1_q <= host_byte_i;
      if (pos == 7'd2) c2_q <= host_byte_i;
    end
  end

  // Decode of the accepted item: flag updates and the job it leaves.
  always_comb begin
    brset_d = brset_q;
    open_d  = open_q;
    listen_d = listen_q;
    apoll_d = apoll_q;
    st_on_d = st_on_q;
    stamp_d = stamp_q;
    job_req_d    = 1'b0;
    job_kind_d   = KIND_BYTE;
    job_txt_d    = TXT_NONE;
    job_id_d     = id_q;
    job_ext_d    = ext_l;
    job_rem_d    = rem_l;
    job_len_d    = len_q;
    job_data_d   = data_q;
    job_rate_d   = 4'd0;
    job_mon_d    = 1'b0;
    job_stamp_d  = stamp_q;
    job_st_on_d  = st_on_q;
    job_status_d = bus_status_i;
    case (cmd_in_i)
      CMD_HOST: begin
        if (host_byte_i == CH_CR) begin
          job_txt_d = TXT_BELL;
          if (!ovf_q && n7 != 7'd0) begin
            case (c0_q)
              CH_S: begin
                if (n7 == 7'd2 && c1_q >= CH_ZERO && c1_q <= CH_EIGHT) begin
                  job_req_d  = 1'b1;
                  job_kind_d = KIND_RATE;
                  job_rate_d = 4'(c1_q - CH_ZERO);
                  brset_d    = 1'b1;
                  job_txt_d  = TXT_CR;
                end
              end
              CH_O, CH_L: begin
                if (n7 == 7'd1 && !open_q && brset_q) begin
                  if (c0_q == CH_L) begin
                    job_req_d  = 1'b1;
                    job_kind_d = KIND_MON;
                    job_mon_d  = 1'b1;
                    listen_d   = 1'b1;
                  end
                  open_d    = 1'b1;
                  apoll_d   = 1'b1;
                  job_txt_d = TXT_CR;
                end
              end
              CH_C: begin
                if (n7 == 7'd1 && open_q) begin
                  if (listen_q) begin
                    job_req_d  = 1'b1;
                    job_kind_d = KIND_MON;
                  end
                  listen_d  = 1'b0;
                  open_d    = 1'b0;
                  job_txt_d = TXT_CR;
                end
              end
              CH_LT, CH_UT, CH_LR, CH_UR: begin
                if (allhex_q && len_q <= MAX_DLC && n7 == endpos && open_q && !listen_q) begin
                  job_req_d  = 1'b1;
                  job_kind_d = KIND_TX;
                  job_txt_d  = apoll_q ? TXT_ZCR : TXT_CR;
                end
              end
              CH_X: begin
                if (n7 == 7'd2 && !open_q) begin
                  if (c1_q == CH_ZERO) apoll_d = 1'b0;
                  else if (c1_q == CH_ONE) apoll_d = 1'b1;
                  job_txt_d = TXT_CR;
                end
              end
              CH_Z: begin
                if (n7 == 7'd2 && !open_q) begin
                  if (c1_q == CH_ZERO || c1_q == CH_ONE) begin
                    st_on_d = c1_q == CH_ONE;
                    stamp_d = 16'd0;
                  end
                  job_txt_d = TXT_CR;
                end
              end
              CH_U: begin
                if (n7 == 7'd2 && !open_q) begin
                  if (c1_q >= CH_ZERO && c1_q <= CH_SIX) begin
                    job_req_d  = 1'b1;
                    job_kind_d = KIND_BAUD;
                    job_rate_d = 4'(c1_q - CH_ZERO);
                  end
                  job_txt_d = TXT_CR;
                end
              end
              CH_F: if (n7 == 7'd1 && open_q) job_txt_d = TXT_FSTAT;
              CH_V: if (n7 == 7'd1) job_txt_d = TXT_VER;
              CH_N: if (n7 == 7'd1) job_txt_d = TXT_SER;
              default: job_txt_d = TXT_BELL;
            endcase
          end
        end
      end
      CMD_FRAME: begin
        if (apoll_q && open_q) begin
          job_txt_d  = TXT_FRAME;
          job_id_d   = {3'd0, rx_id_i};
          job_ext_d  = rx_id_i >= STD_ID_LIMIT;
          job_len_d  = (rx_len_i > MAX_DLC) ? MAX_DLC : rx_len_i;
          job_data_d = rx_data_i;
        end
      end
      CMD_TICK: begin
        if (st_on_q) stamp_d = (inc >= 17'(STAMP_WRAP_MS)) ? 16'd0 : inc[15:0];
      end
      default: job_txt_d = TXT_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      brset_q  <= 1'b0;
      open_q   <= 1'b0;
      listen_q <= 1'b0;
      apoll_q  <= 1'b0;
      st_on_q  <= 1'b0;
      stamp_q  <= 16'd0;
      job_req_q <= 1'b0;
      job_txt_q <= TXT_NONE;
    end else if (cmd_i.take) begin
      if (cmd_in_i == CMD_HOST) begin
        if (host_byte_i == CH_CR) begin
          cnt_q <= '0;
          ovf_q <= 1'b0;
        end else if (store) begin
          cnt_q <= cnt_q + CW'(1);
        end else begin
          ovf_q <= 1'b1;
        end
      end
      brset_q   <= brset_d;
      open_q    <= open_d;
      listen_q  <= listen_d;
      apoll_q   <= apoll_d;
      st_on_q   <= st_on_d;
      stamp_q   <= stamp_d;
      job_req_q <= job_req_d;
      job_txt_q <= job_txt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      job_kind_q   <= job_kind_d;
      job_id_q     <= job_id_d;
      job_ext_q    <= job_ext_d;
      job_rem_q    <= job_rem_d;
      job_len_q    <= job_len_d;
      job_data_q   <= job_data_d;
      job_rate_q   <= job_rate_d;
      job_mon_q    <= job_mon_d;
      job_stamp_q  <= job_stamp_d;
      job_st_on_q  <= job_st_on_d;
      job_status_q <= job_status_d;
    end
  end

  // Result formatter, one result per step.
  logic [5:0] nbytes, total, b, fd, dig_end, dat_end, stp_end, dj;
  logic [3:0] fnib;
  logic [2:0] nidx;
  logic [1:0] sidx;
  logic [7:0] rb;

  always_comb begin
    fd      = job_ext_q ? 6'd8 : 6'd3;
    dig_end = fd + 6'd1;
    dat_end = dig_end + 6'd1 + {1'b0, job_len_q, 1'b0};
    stp_end = dat_end + (job_st_on_q ? 6'd4 : 6'd0);
    case (job_txt_q)
      TXT_BELL, TXT_CR: nbytes = 6'd1;
      TXT_ZCR:          nbytes = 6'd2;
      TXT_FSTAT:        nbytes = 6'd4;
      TXT_VER, TXT_SER: nbytes = 6'd6;
      TXT_FRAME:        nbytes = stp_end + 6'd1;
      default:          nbytes = 6'd0;
    endcase
    total = nbytes + {5'd0, job_req_q};
    b     = cmd_i.step - {5'd0, job_req_q};
    nidx  = 3'(fd - b);
    fnib  = 4'd0;
    sidx  = 2'(b - dat_end);
    // Offset of the current data digit; two digits per byte, high nibble first.
    dj    = b - dig_end - 6'd1;
    if (b == 6'd0) rb = job_ext_q ? CH_UT : CH_LT;
    else if (b <= fd) begin
      fnib = job_id_q[{nidx, 2'b00} +: 4];
      rb   = hex_char(fnib);
    end else if (b == dig_end) rb = hex_char(job_len_q);
    else if (b < dat_end) begin
      fnib = job_data_q[{dj[3:1], ~dj[0], 2'b00} +: 4];
      rb   = hex_char(fnib);
    end else if (b < stp_end) begin
      fnib = job_stamp_q[{~sidx, 2'b00} +: 4];
      rb   = hex_char(fnib);
    end else rb = CH_CR;

    res = '0;
    res.last = cmd_i.step == (total - 6'd1);
    if (job_req_q && cmd_i.step == 6'd0) begin
      res.kind = job_kind_q;
      case (job_kind_q)
        KIND_TX: begin
          res.tx_id       = job_id_q;
          res.tx_extended = job_ext_q;
          res.tx_remote   = job_rem_q;
          res.tx_len      = job_len_q;
          res.tx_data     = job_data_q;
        end
        KIND_RATE, KIND_BAUD: res.rate_code = job_rate_q;
        KIND_MON: res.monitor_on = job_mon_q;
        default: res.kind = job_kind_q;
      endcase
    end else begin
      res.kind = KIND_BYTE;
      case (job_txt_q)
        TXT_BELL: res.reply_byte = CH_BELL;
        TXT_ZCR:  res.reply_byte = (b == 6'd0) ? CH_LZ : CH_CR;
        TXT_FSTAT: begin
          case (b)
            6'd0: res.reply_byte = CH_F;
            6'd1: res.reply_byte = hex_char(job_status_q[7:4]);
            6'd2: res.reply_byte = hex_char(job_status_q[3:0]);
            default: res.reply_byte = CH_CR;
          endcase
        end
        TXT_VER:   res.reply_byte = ver_char(3'(b));
        TXT_SER:   res.reply_byte = ser_char(3'(b));
        TXT_FRAME: res.reply_byte = rb;
        default:   res.reply_byte = CH_CR;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) out_q <= res;
  end

  assign stat_o.total = total;
  assign res_o        = out_q;

endmodule
`default_nettype wire

[hdl/slcan_command_interpreter.sv]
// Top level of the serial-line CAN adapter command interpreter.
// Depends on slcan_pkg, slcan_ctrl and slcan_dp.
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_stall_o   cmd, host_byte, bus_status, rx_*
//   out      source     out_valid_o / out_stall_i kind, reply_byte, last, tx_*, ...
//
// An item is accepted in idle; the sequencer then steps through its result
// words, holding while the output is stalled, and returns to idle once its
// step counter reaches the result total that the datapath reports. Host bytes
// that only extend the line give no result words.
// Reset is asynchronous, active low, and clears the line, flags and timestamp.
// A stalled output holds its word; input is stalled while results are emitted.
`default_nettype none
module slcan_command_interpreter #(
  parameter int LINE_MAX      = 32,
  parameter int STAMP_WRAP_MS = 60000
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  host_byte_i,
  input  logic [7:0]  bus_status_i,
  input  logic [28:0] rx_id_i,
  input  logic [3:0]  rx_len_i,
  input  logic [63:0] rx_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  reply_byte_o,
  output logic        last_o,
  output logic [31:0] tx_id_o,
  output logic        tx_extended_o,
  output logic        tx_remote_o,
  output logic [3:0]  tx_len_o,
  output logic [63:0] tx_data_o,
  output logic [3:0]  rate_code_o,
  output logic        monitor_on_o
);
  import slcan_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;
  res_t     res;

  slcan_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (dp_cmd),
    .stat_i      (dp_stat)
  );

  slcan_dp #(
    .LINE_MAX      (LINE_MAX),
    .STAMP_WRAP_MS (STAMP_WRAP_MS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .cmd_in_i     (cmd_i),
    .host_byte_i  (host_byte_i),
    .bus_status_i (bus_status_i),
    .rx_id_i      (rx_id_i),
    .rx_len_i     (rx_len_i),
    .rx_data_i    (rx_data_i),
    .stat_o       (dp_stat),
    .res_o        (res)
  );

  assign kind_o        = res.kind;
  assign reply_byte_o  = res.reply_byte;
  assign last_o        = res.last;
  assign tx_id_o       = res.tx_id;
  assign tx_extended_o = res.tx_extended;
  assign tx_remote_o   = res.tx_remote;
  assign tx_len_o      = res.tx_len;
  assign tx_data_o     = res.tx_data;
  assign rate_code_o   = res.rate_code;
  assign monitor_on_o  = res.monitor_on;

endmodule
`default_nettype wire

[hdl/slcan_checker.sv]
// Port-level checks for the command interpreter, bound to the top level.
// Depends on slcan_pkg.
`default_nettype none
module slcan_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  kind_o,
  input logic [7:0]  reply_byte_o,
  input logic        last_o,
  input logic [31:0] tx_id_o
);
  import slcan_pkg::*;

  // A request is always followed by at least a CR reply word.
  a_req_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_BYTE |-> !last_o) else $error("request marked last");

  a_req_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_BYTE |-> reply_byte_o == 8'd0)
    else $error("request carries reply byte");

  a_byte_no_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_BYTE |-> tx_id_o == 32'd0)
    else $error("reply word carries identifier");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o) else $error("accepted two words in a row");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("stalled word dropped");

endmodule

bind slcan_command_interpreter slcan_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .kind_o       (kind_o),
  .reply_byte_o (reply_byte_o),
  .last_o       (last_o),
  .tx_id_o      (tx_id_o)
);
`default_nettype wire
